>>> hw/rtl/ipd_pkg.sv
// Types and constants shared by the +IPD frame extractor.
package ipd_pkg;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_I     = 8'h49;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] PRINT_LO = 8'd31;
	localparam logic [7:0] PRINT_HI = 8'd127;

	localparam logic [3:0] PORT_MAX  = 4'd9;
	localparam logic [2:0] LEN_BYTES = 3'd4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FILTER_PRINTABLE = 2'd0,
		CFG_HIGHEST_PORT     = 2'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		PH_HUNT  = 4'd0,
		PH_I     = 4'd1,
		PH_P     = 4'd2,
		PH_D     = 4'd3,
		PH_COMMA = 4'd4,
		PH_PORT  = 4'd5,
		PH_SEP   = 4'd6,
		PH_LEN   = 4'd7,
		PH_PAY   = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_BYTE   = 2'd1,
		KIND_END    = 2'd2,
		KIND_REJECT = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       restart;
	} rx_item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [3:0] port;
		logic [7:0] data_byte;
		logic [7:0] byte_count;
		logic       last;
	} res_item_t;

	// byte as seen by the parser: raw value plus pre-decoded flags
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       restart;
		logic       is_plus;
		logic       is_i;
		logic       is_p;
		logic       is_d;
		logic       is_comma;
		logic       is_colon;
		logic       is_digit;
		logic [3:0] digit;
		logic       is_print;
		logic       is_nul;
	} ipd_class_t;

	typedef struct packed {
		logic filter_printable;
		logic [3:0] highest_port;
	} ipd_cfg_t;

endpackage

>>> hw/rtl/ipd_front.sv
// Front end: takes received words and decodes each byte into parser flags.
module ipd_front (
	input  ipd_pkg::rx_item_t   rx_item,
	input  logic                rx_valid,
	output logic                rx_stall,
	input  logic                q_full,
	output logic                q_push,
	output ipd_pkg::ipd_class_t q_wdata
);
	import ipd_pkg::*;

	logic [7:0] b;

	assign b        = rx_item.rx_byte;
	assign rx_stall = q_full;
	assign q_push   = rx_valid && !q_full;

	always_comb begin
		q_wdata          = '0;
		q_wdata.rx_byte  = b;
		q_wdata.restart  = rx_item.restart;
		q_wdata.is_plus  = (b == CH_PLUS);
		q_wdata.is_i     = (b == CH_I);
		q_wdata.is_p     = (b == CH_P);
		q_wdata.is_d     = (b == CH_D);
		q_wdata.is_comma = (b == CH_COMMA);
		q_wdata.is_colon = (b == CH_COLON);
		q_wdata.is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		q_wdata.digit    = b[3:0];
		q_wdata.is_print = (b > PRINT_LO) && (b < PRINT_HI);
		q_wdata.is_nul   = (b == CH_NUL);
	end

endmodule

>>> hw/rtl/ipd_queue.sv
// Short queue of decoded bytes between front end and parser.
module ipd_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ipd_pkg::ipd_class_t wdata,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output ipd_pkg::ipd_class_t rdata
);
	import ipd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	ipd_class_t       slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

endmodule

>>> hw/rtl/ipd_back.sv
// Parser: walks the +IPD header state machine and registers one result word.
module ipd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ipd_pkg::ipd_cfg_t   cfg,
	input  logic                q_not_empty,
	input  ipd_pkg::ipd_class_t q_rdata,
	output logic                q_pop,
	output logic                res_valid,
	input  logic                res_stall,
	output ipd_pkg::res_item_t  res_item
);
	import ipd_pkg::*;

	phase_t     phase_q, phase_d, cur_ph;
	logic [3:0] frame_port_q, frame_port_d;
	logic [7:0] length_q, length_d;
	logic       digits_open_q, digits_open_d;
	logic [2:0] len_pos_q, len_pos_d;
	logic [7:0] left_q, left_d;
	logic [7:0] passed_q, passed_d;
	logic       res_valid_q;
	res_item_t  res_q;

	logic       emit;
	res_item_t  emit_item;
	logic [3:0] limit;
	logic [7:0] len_acc;
	logic [7:0] left_dec;
	logic [7:0] passed_inc;
	logic       pass_byte;

	assign q_pop     = q_not_empty && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	assign cur_ph     = q_rdata.restart ? PH_HUNT : phase_q;
	assign limit      = (cfg.highest_port > PORT_MAX) ? PORT_MAX : cfg.highest_port;
	assign len_acc    = {length_q[4:0], 3'b000} + {length_q[6:0], 1'b0}
		+ {4'd0, q_rdata.digit};
	assign left_dec   = left_q - 8'd1;
	assign passed_inc = passed_q + 8'd1;
	assign pass_byte  = !cfg.filter_printable || q_rdata.is_print;

	// next phase
	always_comb begin
		phase_d = cur_ph;
		case (cur_ph)
			PH_HUNT: begin
				phase_d = q_rdata.is_plus ? PH_I : PH_HUNT;
			end
			PH_I, PH_P, PH_D, PH_COMMA: begin
				if ((cur_ph == PH_I && q_rdata.is_i) || (cur_ph == PH_P && q_rdata.is_p)
						|| (cur_ph == PH_D && q_rdata.is_d)
						|| (cur_ph == PH_COMMA && q_rdata.is_comma)) begin
					phase_d = phase_t'(cur_ph + 4'd1);
				end else if (q_rdata.is_plus) begin
					phase_d = PH_I;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_PORT: begin
				phase_d = (q_rdata.is_digit && q_rdata.digit <= limit) ? PH_SEP : PH_HUNT;
			end
			PH_SEP: begin
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				if (q_rdata.is_colon) begin
					phase_d = (length_q == '0) ? PH_HUNT : PH_PAY;
				end else if (len_pos_d >= LEN_BYTES) begin
					phase_d = (length_d == '0) ? PH_HUNT : PH_PAY;
				end
			end
			PH_PAY: begin
				if ((cfg.filter_printable && q_rdata.is_nul) || left_dec == '0) begin
					phase_d = PH_HUNT;
				end
			end
			default: begin
				phase_d = q_rdata.is_plus ? PH_I : PH_HUNT;
			end
		endcase
	end

	// datapath updates and result word
	always_comb begin
		frame_port_d  = frame_port_q;
		length_d      = length_q;
		digits_open_d = digits_open_q;
		len_pos_d     = len_pos_q;
		left_d        = left_q;
		passed_d      = passed_q;
		emit          = 1'b0;
		emit_item     = '0;
		case (cur_ph)
			PH_PORT: begin
				if (q_rdata.is_digit && q_rdata.digit <= limit) begin
					frame_port_d = q_rdata.digit;
				end else begin
					emit                  = 1'b1;
					emit_item.result_kind = KIND_REJECT;
					emit_item.last        = 1'b1;
				end
			end
			PH_SEP: begin
				length_d      = '0;
				digits_open_d = 1'b1;
				len_pos_d     = '0;
			end
			PH_LEN: begin
				if (!q_rdata.is_colon) begin
					if (digits_open_q && q_rdata.is_digit) begin
						length_d = len_acc;
					end else begin
						digits_open_d = 1'b0;
					end
					len_pos_d = len_pos_q + 3'd1;
				end
				// a colon, or the fourth length byte, closes the header
				if (q_rdata.is_colon || len_pos_d >= LEN_BYTES) begin
					emit           = 1'b1;
					emit_item.port = frame_port_q;
					if (length_d == '0) begin
						emit_item.result_kind = KIND_REJECT;
						emit_item.last        = 1'b1;
					end else begin
						emit_item.result_kind = KIND_HEADER;
						emit_item.data_byte   = length_d;
						left_d                = length_d;
						passed_d              = '0;
					end
				end
			end
			PH_PAY: begin
				emit_item.port = frame_port_q;
				if (cfg.filter_printable && q_rdata.is_nul) begin
					emit                  = 1'b1;
					emit_item.result_kind = KIND_END;
					emit_item.byte_count  = passed_q;
					emit_item.last        = 1'b1;
				end else begin
					left_d = left_dec;
					if (pass_byte) begin
						passed_d              = passed_inc;
						emit                  = 1'b1;
						emit_item.result_kind = KIND_BYTE;
						emit_item.data_byte   = q_rdata.rx_byte;
						emit_item.byte_count  = passed_inc;
						emit_item.last        = (left_dec == '0);
					end else if (left_dec == '0) begin
						// dropped final byte still closes the frame
						emit                  = 1'b1;
						emit_item.result_kind = KIND_END;
						emit_item.byte_count  = passed_q;
						emit_item.last        = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			frame_port_q  <= '0;
			length_q      <= '0;
			digits_open_q <= 1'b1;
			len_pos_q     <= '0;
			left_q        <= '0;
			passed_q      <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q       <= phase_d;
				frame_port_q  <= frame_port_d;
				length_q      <= length_d;
				digits_open_q <= digits_open_d;
				len_pos_q     <= len_pos_d;
				left_q        <= left_d;
				passed_q      <= passed_d;
				res_valid_q   <= emit;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			res_q <= emit_item;
		end
	end

	a_header_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.result_kind == KIND_HEADER |-> res_q.data_byte != '0)
		else $error("header word with zero length");

	a_reject_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.result_kind == KIND_REJECT |-> res_q.last)
		else $error("reject word not marked last");

	a_byte_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.result_kind == KIND_BYTE |-> res_q.byte_count != '0)
		else $error("payload word with zero count");

	a_pay_has_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAY |-> left_q != '0)
		else $error("payload phase with nothing left");

	a_header_after_len: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && emit && emit_item.result_kind == KIND_HEADER |=> phase_q == PH_PAY)
		else $error("header accepted without entering payload");

endmodule

>>> hw/rtl/ipd_frame_extractor.sv
// +IPD frame extractor top level: config registers, front end, queue and parser.
// Usage:
//   rx channel (rx_valid / rx_stall / rx_item) carries one received modem byte
//   per word, with a restart flag that aborts any frame at that byte.
//   res channel (res_valid / res_stall / res_item) carries zero or one result
//   word per received byte: header accepted, payload byte, payload end or
//   header rejected, tagged with port, running count and a last flag.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   filter_printable (index 0) and highest_port (index 1); cfg_ready is
//   always high. Write only while the block is idle.
// Timing:
//   One byte per cycle sustained while res_stall is low. A byte accepted is
//   written into a queue slot, and its result into the parser's output
//   register. The parser handles one queued byte per cycle unless stalled.
// Stalls:
//   A stalled result holds in the output register; the parser stops and the
//   queue fills, then rx_stall rises once it is full. Nothing is dropped.
// Reset:
//   arst_n clears the queue, the result valid flag and the parser to hunting
//   for '+'; filter_printable resets to 0 and highest_port to 4.
module ipd_frame_extractor #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rx_valid,
	output logic                              rx_stall,
	input  ipd_pkg::rx_item_t                 rx_item,
	output logic                              res_valid,
	input  logic                              res_stall,
	output ipd_pkg::res_item_t                res_item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ipd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ipd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ipd_pkg::*;

	ipd_cfg_t   cfg_q;
	ipd_class_t q_wdata;
	ipd_class_t q_rdata;
	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_not_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_printable <= 1'b0;
			cfg_q.highest_port     <= 4'd4;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FILTER_PRINTABLE: cfg_q.filter_printable <= cfg_data[0];
				CFG_HIGHEST_PORT:     cfg_q.highest_port     <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	ipd_front u_front (
		.rx_item  (rx_item),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	ipd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rdata     (q_rdata)
	);

	ipd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_item    (res_item)
	);

endmodule
